@@ hw/rtl/bol_pkg.sv @@
package bol_pkg;

  // coordinate and field widths
  localparam int COORD_W = 16;
  localparam int PIX_W   = 12;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int TWICE_W = COORD_W + 2;
  localparam int DEC_W   = COORD_W + 3;
  localparam int CMP_W   = ((COORD_W > PIX_W) ? COORD_W : PIX_W) + 1;

  // stream payload widths
  localparam int IN_DATA_W  = 4 * COORD_W;
  localparam int OUT_DATA_W = ((2 * PIX_W + 7) / 8) * 8;

  // screen size after reset
  localparam logic [PIX_W-1:0] WIDTH_RST  = PIX_W'(1920);
  localparam logic [PIX_W-1:0] HEIGHT_RST = PIX_W'(1080);

  // request kinds
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic   mode;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    coord_t                    pos_x;
    coord_t                    pos_y;
    coord_t                    major_end;
    logic signed [DEC_W-1:0]   decision;
    logic [TWICE_W-1:0]        twice_major;
    logic [TWICE_W-1:0]        twice_minor;
    logic                      minor_neg;
    logic                      steep;
  } line_t;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic             last;
  } pixel_t;

  // pixel lies inside 0 <= x < w and 0 <= y < h
  function automatic logic on_screen(coord_t x, coord_t y,
                                     logic [PIX_W-1:0] w, logic [PIX_W-1:0] h);
    logic signed [CMP_W-1:0] xs;
    logic signed [CMP_W-1:0] ys;
    logic signed [CMP_W-1:0] ws;
    logic signed [CMP_W-1:0] hs;
    xs = {{(CMP_W-COORD_W){x[COORD_W-1]}}, x};
    ys = {{(CMP_W-COORD_W){y[COORD_W-1]}}, y};
    ws = {{(CMP_W-PIX_W){1'b0}}, w};
    hs = {{(CMP_W-PIX_W){1'b0}}, h};
    return !x[COORD_W-1] && !y[COORD_W-1] && (xs < ws) && (ys < hs);
  endfunction

endpackage

@@ hw/rtl/bol_in_reg.sv @@
module bol_in_reg
  import bol_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // start_x, start_y, end_x, end_y
  input  logic                 in_tuser,   // mode
  input  logic                 take,
  output logic                 item_vld,
  output in_item_t             item
);

  logic     vld_r;
  logic     vld_nxt;
  in_item_t item_r;

  // free slot, or the held request leaves this cycle
  assign in_tready = !vld_r || take;
  assign vld_nxt   = in_tvalid || (vld_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= vld_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.mode    <= in_tuser;
      item_r.start_x <= in_tdata[COORD_W-1:0];
      item_r.start_y <= in_tdata[2*COORD_W-1:COORD_W];
      item_r.end_x   <= in_tdata[3*COORD_W-1:2*COORD_W];
      item_r.end_y   <= in_tdata[4*COORD_W-1:3*COORD_W];
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

@@ hw/rtl/bol_setup.sv @@
module bol_setup
  import bol_pkg::*;
(
  input  in_item_t         item,
  input  logic [PIX_W-1:0] width,
  input  logic [PIX_W-1:0] height,
  output line_t            line,
  output logic             active
);

  logic signed [DIFF_W-1:0] diff_x;
  logic signed [DIFF_W-1:0] diff_y;
  logic [DIFF_W-1:0]        adx;
  logic [DIFF_W-1:0]        ady;
  logic [DIFF_W-1:0]        maj;
  logic [DIFF_W-1:0]        mnr;
  logic                     steep;
  logic                     swap;
  coord_t                   m0;
  coord_t                   m1;

  // absolute deltas
  assign diff_x = {item.end_x[COORD_W-1], item.end_x} - {item.start_x[COORD_W-1], item.start_x};
  assign diff_y = {item.end_y[COORD_W-1], item.end_y} - {item.start_y[COORD_W-1], item.start_y};
  assign adx    = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
  assign ady    = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);

  // octant choice and endpoint order
  assign steep = (ady >= adx);
  assign swap  = steep ? (item.start_y >= item.end_y) : (item.start_x >= item.end_x);
  assign maj   = steep ? ady : adx;
  assign mnr   = steep ? adx : ady;
  assign m0    = steep ? item.start_x : item.start_y;
  assign m1    = steep ? item.end_x : item.end_y;

  always_comb begin
    line.steep       = steep;
    line.minor_neg   = swap ? (m0 < m1) : (m1 < m0);
    line.twice_major = {maj, 1'b0};
    line.twice_minor = {mnr, 1'b0};
    line.decision    = $signed({1'b0, mnr, 1'b0}) - $signed({2'b00, maj});
    line.pos_x       = swap ? item.end_x : item.start_x;
    line.pos_y       = swap ? item.end_y : item.start_y;
    if (steep) begin
      line.major_end = swap ? item.start_y : item.end_y;
    end else begin
      line.major_end = swap ? item.start_x : item.end_x;
    end
  end

  assign active = on_screen(line.pos_x, line.pos_y, width, height);

endmodule

@@ hw/rtl/bol_step.sv @@
module bol_step
  import bol_pkg::*;
(
  input  line_t            cur,
  input  logic             active,
  input  logic [PIX_W-1:0] width,
  input  logic [PIX_W-1:0] height,
  output line_t            nxt,
  output logic             active_nxt,
  output pixel_t           pix
);

  logic                      draw;
  logic                      at_end;
  logic                      dec_pos;
  logic                      last;
  coord_t                    major;
  coord_t                    minor;
  coord_t                    minor_nxt;
  coord_t                    nx;
  coord_t                    ny;
  logic signed [DEC_W:0]     dec_ext;
  logic signed [DEC_W:0]     dec_sum;

  assign draw   = active && on_screen(cur.pos_x, cur.pos_y, width, height);
  assign major  = cur.steep ? cur.pos_y : cur.pos_x;
  assign minor  = cur.steep ? cur.pos_x : cur.pos_y;
  assign at_end = (major >= cur.major_end);

  // decision update and minor move
  assign dec_pos   = (cur.decision > 0);
  assign minor_nxt = !dec_pos ? minor :
                     (cur.minor_neg ? minor - coord_t'(1) : minor + coord_t'(1));
  assign dec_ext   = {cur.decision[DEC_W-1], cur.decision};
  assign dec_sum   = dec_ext
                     - (dec_pos ? $signed({2'b00, cur.twice_major}) : '0)
                     + $signed({2'b00, cur.twice_minor});

  // major axis always advances by one
  assign nx = cur.steep ? minor_nxt : cur.pos_x + coord_t'(1);
  assign ny = cur.steep ? cur.pos_y + coord_t'(1) : minor_nxt;

  assign last = at_end || !on_screen(nx, ny, width, height);

  always_comb begin
    nxt = cur;
    if (draw && !at_end) begin
      nxt.pos_x    = nx;
      nxt.pos_y    = ny;
      nxt.decision = dec_sum[DEC_W-1:0];
    end
  end

  assign active_nxt = draw && !last;

  // result, all zero when nothing is drawn
  assign pix.valid = draw;
  assign pix.x     = draw ? PIX_W'(cur.pos_x) : '0;
  assign pix.y     = draw ? PIX_W'(cur.pos_y) : '0;
  assign pix.last  = draw && last;

endmodule

@@ hw/rtl/bresenham_octant_line.sv @@
// a step request's pixel is registered and appears on out_ in the cycle after the request is taken
// throughput: one request per clock unless held; a start request gives no result and needs no output space
// a request waits only while a step request is held and the output register is full and not
// being taken
// reset (rst_n low, synchronous): no line active, screen size 1920 x 1080
module bresenham_octant_line
  import bol_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,    // start_x, start_y, end_x, end_y
  input  logic                  in_tuser,    // mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // pixel_x, pixel_y
  output logic                  out_tuser,   // pixel_valid
  output logic                  out_tlast,   // last
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  logic [PIX_W-1:0] width_r;
  logic [PIX_W-1:0] height_r;
  logic             cfg_wr;

  in_item_t item;
  logic     item_vld;
  logic     fire;
  logic     out_free;

  line_t    line_r;
  line_t    line_nxt;
  logic     active_r;
  logic     active_nxt;
  line_t    setup_line;
  logic     setup_active;
  line_t    step_line;
  logic     step_active;
  pixel_t   step_pix;
  pixel_t   pix_r;
  logic     out_vld_r;
  logic     out_vld_nxt;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_HEIGHT) ? {{(32-PIX_W){1'b0}}, height_r}
                                                   : {{(32-PIX_W){1'b0}}, width_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_WIDTH) begin
        width_r <= cfg_pwdata[PIX_W-1:0];
      end else begin
        height_r <= cfg_pwdata[PIX_W-1:0];
      end
    end
  end

  // input register
  bol_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .take      (fire),
    .item_vld  (item_vld),
    .item      (item)
  );

  // a start request never needs output space
  assign out_free = !out_vld_r || out_tready;
  assign fire     = item_vld && ((item.mode == MODE_START) || out_free);

  bol_setup u_setup (
    .item   (item),
    .width  (width_r),
    .height (height_r),
    .line   (setup_line),
    .active (setup_active)
  );

  bol_step u_step (
    .cur        (line_r),
    .active     (active_r),
    .width      (width_r),
    .height     (height_r),
    .nxt        (step_line),
    .active_nxt (step_active),
    .pix        (step_pix)
  );

  // line state
  assign line_nxt   = (item.mode == MODE_START) ? setup_line : step_line;
  assign active_nxt = (item.mode == MODE_START) ? setup_active : step_active;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r   <= '0;
      active_r <= 1'b0;
    end else if (fire) begin
      line_r   <= line_nxt;
      active_r <= active_nxt;
    end
  end

  // output register
  assign out_vld_nxt = (fire && (item.mode == MODE_STEP)) || (out_vld_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (item.mode == MODE_STEP)) begin
      pix_r <= step_pix;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = pix_r.valid;
  assign out_tlast  = pix_r.last;
  assign out_tdata  = OUT_DATA_W'({pix_r.y, pix_r.x});

  // checks
  a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0 && !out_tlast))
    else $error("empty result carries data");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.mode == MODE_STEP && step_pix.last) |=> !active_r)
    else $error("line still active after last pixel");

  a_major_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> ((line_r.steep ? line_r.pos_y : line_r.pos_x) <= line_r.major_end))
    else $error("major coordinate passed line end");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !item_vld |-> in_tready)
    else $error("input stalled with empty register");

endmodule
